// ----- design/lpmr_pkg.sv -----
package lpmr_pkg;

  localparam int unsigned ALU_W = 33;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_POP  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_TOO_BIG    = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;
  localparam logic [2:0] ST_BAD_LEN    = 3'd5;
  localparam logic [2:0] ST_SEQ        = 3'd6;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             lt;
  } alu_rsp_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } res_t;

endpackage

// ----- design/lpmr_if.sv -----
interface lpmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] msg_type;
  logic [15:0] data_len;
  logic [7:0]  payload_byte;

  modport source (output valid, kind, msg_type, data_len, payload_byte, input ready);
  modport sink (input valid, kind, msg_type, data_len, payload_byte, output ready);
endinterface

interface lpmr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic [9:0] stored_messages;

  modport source (output valid, status, out_byte, out_valid, out_last, stored_messages,
                  input ready);
  modport sink (input valid, status, out_byte, out_valid, out_last, stored_messages,
                output ready);
endinterface

// ----- design/length_prefixed_message_ring.sv -----
// channel  dir  handshake    payload
// in_ch    in   valid/ready  kind, msg_type, data_len, payload_byte
// out_ch   out  valid/ready  status, out_byte, out_valid, out_last, stored_messages
//
// payload byte item: one ram write from idle; pop item inside an open message: S_P_RD then S_P_OUT
// push header item: four checks on the shared adder/subtractor, then eight byte
//   writes through the single ram write port
// pop item that opens a message: free/used checks on the shared adder/subtractor
//   plus four length bytes fetched through the registered ram read port
// reset is synchronous, active low; ring contents are not cleared
// in_ch.ready is high only while the sequencer is idle; a result still waiting in
//   the output register holds the next item in its last cycle
module length_prefixed_message_ring #(
  parameter int RING_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  lpmr_in_if.sink           in_ch,
  lpmr_out_if.source        out_ch
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int LW = PW + 1;
  localparam int CW = $clog2(RING_BYTES / 8 + 1);
  localparam logic [LW-1:0] RING_L = LW'(RING_BYTES);
  localparam logic [lpmr_pkg::ALU_W-1:0] RING_W = lpmr_pkg::ALU_W'(RING_BYTES);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_H_BIG   = 5'd1;
  localparam logic [4:0] S_H_USED  = 5'd2;
  localparam logic [4:0] S_H_FREE  = 5'd3;
  localparam logic [4:0] S_H_CHK   = 5'd4;
  localparam logic [4:0] S_H_WR    = 5'd5;
  localparam logic [4:0] S_P_USED  = 5'd6;
  localparam logic [4:0] S_P_AVAIL = 5'd7;
  localparam logic [4:0] S_P_SHORT = 5'd8;
  localparam logic [4:0] S_P_LEN   = 5'd9;
  localparam logic [4:0] S_P_LENW  = 5'd10;
  localparam logic [4:0] S_P_V1    = 5'd11;
  localparam logic [4:0] S_P_V2    = 5'd12;
  localparam logic [4:0] S_P_V3    = 5'd13;
  localparam logic [4:0] S_P_RD    = 5'd14;
  localparam logic [4:0] S_P_OUT   = 5'd15;
  localparam logic [4:0] S_DONE    = 5'd16;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    ring_inc = (p == PW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  // control state
  logic [4:0]    state_r, state_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] push_cur_r, push_cur_nxt;
  logic [LW-1:0] push_left_r, push_left_nxt;
  logic [PW-1:0] pop_cur_r, pop_cur_nxt;
  logic [LW-1:0] pop_left_r, pop_left_nxt;
  logic          out_vld_r, out_vld_nxt;

  // working registers
  logic [31:0]   type_r, type_nxt;
  logic [15:0]   dlen_r, dlen_nxt;
  logic [LW-1:0] d_r, d_nxt;
  logic          lt_r, lt_nxt;
  logic [LW-1:0] room_r, room_nxt;
  logic [31:0]   len_r, len_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  lpmr_pkg::res_t res_r, res_nxt;

  // output register
  logic [2:0]    out_status_r;
  logic [7:0]    out_byte_r;
  logic          out_flag_r;
  logic          out_last_r;
  logic [9:0]    out_cnt_r;
  logic          out_load;

  logic          in_fire;
  logic [16:0]   total;
  logic [63:0]   hdr_word;
  logic [CW+9:0] cnt_wide;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  lpmr_pkg::alu_req_t alu_req;
  lpmr_pkg::alu_rsp_t alu_rsp;

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpmr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign total       = 17'(dlen_r) + 17'd8;
  assign hdr_word    = {type_r, 15'b0, total};
  assign cnt_wide    = (CW + 10)'(count_r);

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.out_byte        = out_byte_r;
  assign out_ch.out_valid       = out_flag_r;
  assign out_ch.out_last        = out_last_r;
  assign out_ch.stored_messages = out_cnt_r;

  // operand selection for the shared adder/subtractor
  always_comb begin
    alu_req.op = lpmr_pkg::ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_r)
      S_H_BIG: begin
        alu_req.a = RING_W;
        alu_req.b = lpmr_pkg::ALU_W'(total);
      end
      S_H_USED, S_P_USED: begin
        alu_req.a = lpmr_pkg::ALU_W'(wr_ptr_r);
        alu_req.b = lpmr_pkg::ALU_W'(rd_ptr_r);
      end
      S_H_FREE: begin
        alu_req.a = lt_r ? '0 : RING_W;
        alu_req.b = lpmr_pkg::ALU_W'(d_r);
      end
      S_H_CHK: begin
        alu_req.a = lpmr_pkg::ALU_W'(room_r);
        alu_req.b = lpmr_pkg::ALU_W'(total);
      end
      S_P_AVAIL: begin
        alu_req.op = lpmr_pkg::ALU_ADD;
        alu_req.a  = RING_W;
        alu_req.b  = lpmr_pkg::ALU_W'(d_r);
      end
      S_P_SHORT: begin
        alu_req.a = lpmr_pkg::ALU_W'(room_r);
        alu_req.b = lpmr_pkg::ALU_W'(4);
      end
      S_P_V1: begin
        alu_req.a = RING_W;
        alu_req.b = lpmr_pkg::ALU_W'(len_r);
      end
      S_P_V2: begin
        alu_req.a = lpmr_pkg::ALU_W'(room_r);
        alu_req.b = lpmr_pkg::ALU_W'(len_r);
      end
      S_P_V3: begin
        alu_req.a = lpmr_pkg::ALU_W'(len_r);
        alu_req.b = lpmr_pkg::ALU_W'(8);
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    push_cur_nxt  = push_cur_r;
    push_left_nxt = push_left_r;
    pop_cur_nxt   = pop_cur_r;
    pop_left_nxt  = pop_left_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_load      = 1'b0;
    type_nxt      = type_r;
    dlen_nxt      = dlen_r;
    d_nxt         = d_r;
    lt_nxt        = lt_r;
    room_nxt      = room_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = hdr_word[{cnt_r, 3'b000} +: 8];
    ram_re        = 1'b0;
    ram_raddr     = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          type_nxt = in_ch.msg_type;
          dlen_nxt = in_ch.data_len;
          res_nxt  = '0;
          unique case (in_ch.kind)
            lpmr_pkg::KIND_HDR: begin
              // a new header drops any open push
              push_left_nxt = '0;
              state_nxt     = S_H_BIG;
            end
            lpmr_pkg::KIND_BYTE: begin
              state_nxt = S_DONE;
              if (push_left_r == '0) begin
                res_nxt.status = lpmr_pkg::ST_SEQ;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = push_cur_r;
                ram_wdata     = in_ch.payload_byte;
                push_cur_nxt  = ring_inc(push_cur_r);
                push_left_nxt = push_left_r - 1'b1;
                if (push_left_r == LW'(1)) begin
                  wr_ptr_nxt = ring_inc(push_cur_r);
                  count_nxt  = count_r + 1'b1;
                end
              end
            end
            lpmr_pkg::KIND_POP: begin
              if (pop_left_r != '0) begin
                state_nxt = S_P_RD;
              end else if (count_r == '0) begin
                res_nxt.status = lpmr_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_P_USED;
              end
            end
            default: begin
              res_nxt.status = lpmr_pkg::ST_SEQ;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_H_BIG: begin
        if (alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_TOO_BIG;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_H_USED;
        end
      end

      S_H_USED: begin
        d_nxt     = alu_rsp.res[LW-1:0];
        lt_nxt    = alu_rsp.lt;
        state_nxt = S_H_FREE;
      end

      S_H_FREE: begin
        cur_nxt = wr_ptr_r;
        cnt_nxt = '0;
        if (d_r == '0) begin
          // pointers equal: either empty ring or completely full
          if (count_r != '0) begin
            res_nxt.status = lpmr_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_H_WR;
          end
        end else begin
          room_nxt  = alu_rsp.res[LW-1:0];
          state_nxt = S_H_CHK;
        end
      end

      S_H_CHK: begin
        if (alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_H_WR;
        end
      end

      S_H_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        cur_nxt   = ring_inc(cur_r);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 3'd7) begin
          push_cur_nxt  = ring_inc(cur_r);
          push_left_nxt = LW'(dlen_r);
          if (dlen_r == '0) begin
            wr_ptr_nxt = ring_inc(cur_r);
            count_nxt  = count_r + 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_P_USED: begin
        d_nxt     = alu_rsp.res[LW-1:0];
        lt_nxt    = alu_rsp.lt;
        state_nxt = S_P_AVAIL;
      end

      S_P_AVAIL: begin
        if (lt_r) begin
          room_nxt = alu_rsp.res[LW-1:0];
        end else if (d_r == '0) begin
          room_nxt = RING_L;
        end else begin
          room_nxt = d_r;
        end
        state_nxt = S_P_SHORT;
      end

      S_P_SHORT: begin
        cur_nxt = rd_ptr_r;
        cnt_nxt = '0;
        if (alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_INCOMPLETE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_P_LEN;
        end
      end

      S_P_LEN: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
        cur_nxt   = ring_inc(cur_r);
        state_nxt = S_P_LENW;
      end

      S_P_LENW: begin
        // little-endian: bytes shift in from the top
        len_nxt   = {ram_rdata, len_r[31:8]};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_r == 3'd3) ? S_P_V1 : S_P_LEN;
      end

      S_P_V1: begin
        if (len_r[31] || alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_BAD_LEN;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_P_V2;
        end
      end

      S_P_V2: begin
        if (alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_BAD_LEN;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_P_V3;
        end
      end

      S_P_V3: begin
        if (alu_rsp.lt) begin
          res_nxt.status = lpmr_pkg::ST_BAD_LEN;
          state_nxt      = S_DONE;
        end else begin
          pop_cur_nxt  = rd_ptr_r;
          pop_left_nxt = LW'(len_r);
          state_nxt    = S_P_RD;
        end
      end

      S_P_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pop_cur_r;
        state_nxt = S_P_OUT;
      end

      S_P_OUT: begin
        res_nxt.status    = lpmr_pkg::ST_OK;
        res_nxt.out_byte  = ram_rdata;
        res_nxt.out_valid = 1'b1;
        res_nxt.out_last  = (pop_left_r == LW'(1));
        pop_cur_nxt       = ring_inc(pop_cur_r);
        pop_left_nxt      = pop_left_r - 1'b1;
        if (pop_left_r == LW'(1)) begin
          rd_ptr_nxt = ring_inc(pop_cur_r);
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      push_cur_r  <= '0;
      push_left_r <= '0;
      pop_cur_r   <= '0;
      pop_left_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      push_cur_r  <= push_cur_nxt;
      push_left_r <= push_left_nxt;
      pop_cur_r   <= pop_cur_nxt;
      pop_left_r  <= pop_left_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    dlen_r <= dlen_nxt;
    d_r    <= d_nxt;
    lt_r   <= lt_nxt;
    room_r <= room_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_status_r <= res_r.status;
      out_byte_r   <= res_r.out_byte;
      out_flag_r   <= res_r.out_valid;
      out_last_r   <= res_r.out_last;
      out_cnt_r    <= cnt_wide[9:0];
    end
  end

`ifndef SYNTHESIS
  a_pop_committed: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_left_r != '0) |-> (count_r != '0))
    else $error("message being popped is not counted as stored");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push_left_r <= LW'(RING_BYTES - 8))
    else $error("open push longer than the ring allows");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after taking an item");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_H_WR))
    else $error("ring write outside a push");
`endif

endmodule

// ----- design/lpmr_ram.sv -----
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/lpmr_alu.sv -----
module lpmr_alu (
  input  lpmr_pkg::alu_req_t req,
  output lpmr_pkg::alu_rsp_t rsp
);

  logic [lpmr_pkg::ALU_W:0] ext_a;
  logic [lpmr_pkg::ALU_W:0] ext_b;
  logic [lpmr_pkg::ALU_W:0] sum;

  assign ext_a = {1'b0, req.a};
  assign ext_b = {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      lpmr_pkg::ALU_ADD: sum = ext_a + ext_b;
      lpmr_pkg::ALU_SUB: sum = ext_a - ext_b;
      default:           sum = ext_a - ext_b;
    endcase
  end

  // borrow out of the subtract means a < b
  assign rsp.res = sum[lpmr_pkg::ALU_W-1:0];
  assign rsp.lt  = (req.op == lpmr_pkg::ALU_SUB) && sum[lpmr_pkg::ALU_W];

endmodule

// ----- dv/length_prefixed_message_ring_test.sv -----
`timescale 1ns / 1ps

module length_prefixed_message_ring_test;

  localparam int RING_BYTES = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TOTAL_ITEMS = 650;
  localparam int PHASE_ITEMS = 160;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX = 10;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [9:0] stored;
  } ring_reply_t;

  class ring_tracker;
    logic [7:0]  store [RING_BYTES];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    int unsigned held;
    int unsigned push_cur;
    int unsigned push_left;
    int unsigned pop_cur;
    int unsigned pop_left;
    logic [2:0]  last_status;
    logic        last_byte;
    int unsigned mismatches;
    ring_reply_t replies [$];

    function new();
      foreach (store[i]) store[i] = 8'h00;
      wr_ptr = 0;
      rd_ptr = 0;
      held = 0;
      push_cur = 0;
      push_left = 0;
      pop_cur = 0;
      pop_left = 0;
      last_status = lpmr_pkg::ST_OK;
      last_byte = 1'b0;
      mismatches = 0;
    endfunction

    function void commit();
      wr_ptr = push_cur;
      held++;
    endfunction

    function void apply_item(logic [1:0] kind, logic [31:0] mtype, logic [15:0] dlen,
                             logic [7:0] pbyte);
      ring_reply_t r;
      logic [31:0] total;
      logic [31:0] word;
      int unsigned room;
      int unsigned avail;
      r = '0;
      r.status = lpmr_pkg::ST_OK;
      case (kind)
        lpmr_pkg::KIND_HDR: begin
          total = 32'(dlen) + 32'd8;
          push_left = 0;
          if (wr_ptr < rd_ptr) room = rd_ptr - wr_ptr;
          else if (wr_ptr > rd_ptr) room = RING_BYTES - wr_ptr + rd_ptr;
          else room = (held > 0) ? 0 : RING_BYTES;
          if (total > RING_BYTES) begin
            r.status = lpmr_pkg::ST_TOO_BIG;
          end else if (room < total) begin
            r.status = lpmr_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < 4; i++) begin
              store[(wr_ptr + i) % RING_BYTES] = total[8*i +: 8];
              store[(wr_ptr + 4 + i) % RING_BYTES] = mtype[8*i +: 8];
            end
            push_cur = (wr_ptr + 8) % RING_BYTES;
            push_left = dlen;
            if (dlen == 0) commit();
          end
        end
        lpmr_pkg::KIND_BYTE: begin
          if (push_left == 0) begin
            r.status = lpmr_pkg::ST_SEQ;
          end else begin
            store[push_cur] = pbyte;
            push_cur = (push_cur + 1) % RING_BYTES;
            push_left--;
            if (push_left == 0) commit();
          end
        end
        lpmr_pkg::KIND_POP: begin
          if (pop_left == 0) begin
            avail = (wr_ptr + RING_BYTES - rd_ptr) % RING_BYTES;
            if (avail == 0) avail = RING_BYTES;
            for (int i = 0; i < 4; i++) word[8*i +: 8] = store[(rd_ptr + i) % RING_BYTES];
            if (held == 0) begin
              r.status = lpmr_pkg::ST_EMPTY;
            end else if (avail < 4) begin
              r.status = lpmr_pkg::ST_INCOMPLETE;
            end else if (word[31] || word > RING_BYTES || word > avail || word < 8) begin
              r.status = lpmr_pkg::ST_BAD_LEN;
            end else begin
              pop_cur = rd_ptr;
              pop_left = word;
            end
          end
          if (r.status == lpmr_pkg::ST_OK && pop_left > 0) begin
            r.data = store[pop_cur];
            r.valid = 1'b1;
            pop_cur = (pop_cur + 1) % RING_BYTES;
            pop_left--;
            if (pop_left == 0) begin
              r.last = 1'b1;
              rd_ptr = pop_cur;
              if (held > 0) held--;
            end
          end
        end
        default: r.status = lpmr_pkg::ST_SEQ;
      endcase
      r.stored = 10'(held);
      last_status = r.status;
      last_byte = r.last;
      replies.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_response(ring_reply_t got);
      ring_reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected item, status %0d byte %0h", $time, got.status, got.data);
      end else begin
        want = replies.pop_front();
        if (got.status !== want.status) flag("status", want.status, got.status);
        if (got.data !== want.data) flag("out_byte", want.data, got.data);
        if (got.valid !== want.valid) flag("out_valid", want.valid, got.valid);
        if (got.last !== want.last) flag("out_last", want.last, got.last);
        if (got.stored !== want.stored) flag("stored_messages", want.stored, got.stored);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  ring_tracker tracker;

  lpmr_in_if in_ch ();
  lpmr_out_if out_ch ();

  length_prefixed_message_ring #(.RING_BYTES(RING_BYTES)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_response({out_ch.status, out_ch.out_byte, out_ch.out_valid,
                              out_ch.out_last, out_ch.stored_messages});
    end
  end

  task automatic send_item(logic [1:0] kind, logic [31:0] mtype, logic [15:0] dlen,
                           logic [7:0] pbyte);
    case ((items_sent / PHASE_ITEMS) % 4)
      0: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct = 80;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct = 0;
        rx_stall_pct = 80;
      end
      default: begin
        tx_idle_pct = 25;
        rx_stall_pct = 25;
      end
    endcase
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.msg_type <= mtype;
    in_ch.data_len <= dlen;
    in_ch.payload_byte <= pbyte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.apply_item(kind, mtype, dlen, pbyte);
    items_sent++;
  endtask

  // header then its payload; a cut push stops early and stays open
  task automatic push_message(logic [15:0] dlen, bit cut);
    int unsigned n;
    send_item(lpmr_pkg::KIND_HDR, $urandom, dlen, 8'($urandom));
    n = tracker.push_left;
    if (cut && n > 0) n = $urandom_range(0, n - 1);
    repeat (n) send_item(lpmr_pkg::KIND_BYTE, $urandom, 16'($urandom), 8'($urandom));
  endtask

  task automatic pop_message(bit cut);
    int unsigned cap;
    cap = cut ? $urandom_range(1, 12) : RING_BYTES + 1;
    do begin
      send_item(lpmr_pkg::KIND_POP, $urandom, 16'($urandom), 8'($urandom));
      cap--;
    end while (tracker.last_status == lpmr_pkg::ST_OK && !tracker.last_byte && cap > 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned sel;
    logic [15:0] dlen;
    tracker = new();
    in_ch.valid = 1'b0;
    in_ch.kind = lpmr_pkg::KIND_HDR;
    in_ch.msg_type = '0;
    in_ch.data_len = '0;
    in_ch.payload_byte = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring, stray byte, unused kind, oversize headers
    send_item(lpmr_pkg::KIND_POP, 32'h0, 16'h0, 8'h00);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'hFF);
    send_item(KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(lpmr_pkg::KIND_HDR, 32'h0, 16'hFFFF, 8'h00);
    send_item(lpmr_pkg::KIND_HDR, 32'h1234_5678, 16'(RING_BYTES - 7), 8'h00);
    // exact fit, then dropped by a zero-length header
    send_item(lpmr_pkg::KIND_HDR, 32'hFFFF_FFFF, 16'(RING_BYTES - 8), 8'h00);
    send_item(lpmr_pkg::KIND_HDR, 32'hFFFF_FFFF, 16'h0, 8'h00);
    send_item(lpmr_pkg::KIND_HDR, 32'h5AA5_C33C, 16'd3, 8'h00);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'h00);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'hFF);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'hA5);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'h77);
    repeat (8) send_item(lpmr_pkg::KIND_POP, 32'h0, 16'h0, 8'h00);
    repeat (4) send_item(lpmr_pkg::KIND_POP, 32'h0, 16'h0, 8'h00);
    // pushes while a pop is in progress
    send_item(lpmr_pkg::KIND_HDR, 32'h0BAD_F00D, 16'd2, 8'h00);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'h3C);
    send_item(lpmr_pkg::KIND_HDR, 32'h8000_0001, 16'd1, 8'h00);
    send_item(lpmr_pkg::KIND_BYTE, 32'h0, 16'h0, 8'hC3);
    pop_message(1'b0);

    // fill with short records across the wrap until the ring refuses
    do begin
      send_item(lpmr_pkg::KIND_HDR, $urandom, 16'h0, 8'($urandom));
    end while (tracker.last_status == lpmr_pkg::ST_OK);
    repeat (2) push_message(16'($urandom_range(0, 24)), 1'b0);

    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) dlen = 16'($urandom_range(0, 24));
        else if (sel < 95) dlen = 16'($urandom_range(25, 300));
        else if (sel < 98) dlen = 16'($urandom_range(RING_BYTES - 7, 65535));
        else dlen = 16'($urandom);
        push_message(dlen, $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        pop_message($urandom_range(0, 9) == 0);
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(lpmr_pkg::KIND_POP, $urandom, 16'($urandom), 8'($urandom));
          1: send_item(lpmr_pkg::KIND_BYTE, $urandom, 16'($urandom), 8'($urandom));
          2: send_item(KIND_SPARE, $urandom, 16'($urandom), 8'($urandom));
          default: send_item(lpmr_pkg::KIND_HDR, $urandom, 16'($urandom), 8'($urandom));
        endcase
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
